>>> design/positional_list_engine_core_assert.svh
// assertion macros for the positional list engine
// used by the top level only; expects clk and rst_n in scope
`ifndef POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH

// property checked at every clock edge outside reset
`define PLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a condition in the next
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ple_pkg.sv
// shared types and constants for the positional list engine
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package ple_pkg;

    localparam int MAX_DEPTH     = 64;
    localparam int DEFAULT_DEPTH = 32;
    localparam int MAX_RESULTS   = 32;
    localparam int PTR_W         = $clog2(MAX_DEPTH + 1);
    localparam int VALUE_W       = 32;
    localparam int OP_W          = 3;
    localparam int POS_W         = 6;
    localparam int STATUS_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DELETE    = 3'd3,
        OP_SEARCH    = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_RANGE     = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_DELETE,
        ACT_SEARCH
    } cell_act_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        cell_act_t                  act;
        logic [PTR_W-1:0]           idx;
        logic [PTR_W-1:0]           count;
        logic signed [VALUE_W-1:0]  value;
    } cell_cmd_t;

    typedef struct packed {
        status_t           status;
        logic [POS_W-1:0]  position_res;
        logic [POS_W-1:0]  count;
        logic              last;
    } rsp_t;

endpackage

`default_nettype wire

>>> design/ple_req_if.sv
// request channel: op, value and position with valid/ready
// depends on ple_pkg for field widths
`default_nettype none

interface ple_req_if;

    logic                                valid;
    logic                                ready;
    logic [ple_pkg::OP_W-1:0]            op;
    logic signed [ple_pkg::VALUE_W-1:0]  value;
    logic [ple_pkg::POS_W-1:0]           position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);

endinterface

`default_nettype wire

>>> design/ple_rsp_if.sv
// result channel: status, match position, count and last flag with valid/ready
// depends on ple_pkg for field widths
`default_nettype none

interface ple_rsp_if;

    logic                               valid;
    logic                               ready;
    logic [ple_pkg::STATUS_W-1:0]       status;
    logic [ple_pkg::POS_W-1:0]          position_res;
    logic [ple_pkg::POS_W-1:0]          count;
    logic                               last;

    modport source (output valid, output status, output position_res, output count,
                    output last, input ready);
    modport sink   (input valid, input status, input position_res, input count,
                    input last, output ready);

endinterface

`default_nettype wire

>>> design/ple_cell.sv
// one list slot: holds an entry, shifts with its neighbors, keeps a match flag
// depends on ple_pkg for the command struct
`default_nettype none

module ple_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ple_pkg::cell_cmd_t                  cmd,
    input  wire logic signed [ple_pkg::VALUE_W-1:0]  left_data,
    input  wire logic signed [ple_pkg::VALUE_W-1:0]  right_data,
    input  wire logic                                advance,
    input  wire logic                                prior_in,
    output logic signed [ple_pkg::VALUE_W-1:0]       data,
    output logic                                     match,
    output logic                                     first,
    output logic                                     prior_out
);

    localparam logic [ple_pkg::PTR_W-1:0] IDX = ple_pkg::PTR_W'(INDEX);

    logic signed [ple_pkg::VALUE_W-1:0] data_reg;
    logic                               match_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.act)
            ple_pkg::ACT_INSERT:
            begin
                if (IDX > cmd.idx)
                begin
                    data_reg <= left_data;
                end
                else if (IDX == cmd.idx)
                begin
                    data_reg <= cmd.value;
                end
            end
            ple_pkg::ACT_DELETE:
            begin
                if (IDX >= cmd.idx)
                begin
                    data_reg <= right_data;
                end
            end
            default:
            begin
                data_reg <= data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (cmd.act == ple_pkg::ACT_SEARCH)
        begin
            match_reg <= (data_reg == cmd.value) && (IDX < cmd.count);
        end
        else if (advance && first)
        begin
            match_reg <= 1'b0;
        end
    end

    // lowest pending match in the chain wins
    assign first     = match_reg && !prior_in;
    assign prior_out = prior_in || match_reg;
    assign match     = match_reg;
    assign data      = data_reg;

endmodule

`default_nettype wire

>>> design/positional_list_engine_core.sv
// positional list engine: insert, delete and search on an ordered list held in a cell chain
// insert, delete and other requests: result ready the cycle after acceptance
// search of a non-empty list: flags latched first, then one hit a cycle unless the queue is full
// empty-list search: answered like the others; a full result queue holds off requests and the scan
// results pass through a two-entry queue, so a request is taken while an earlier result waits
// reset clears the entry count, the match flags and the queue; entries are undefined until written
`default_nettype none

module positional_list_engine_core #(
    parameter int DEPTH = ple_pkg::DEFAULT_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ple_req_if.sink    req,
    ple_rsp_if.source  rsp
);

    `include "positional_list_engine_core_assert.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RES_W = $clog2(ple_pkg::MAX_RESULTS);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [RES_W-1:0] LAST_RES   = RES_W'(ple_pkg::MAX_RESULTS - 1);

    ple_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [RES_W-1:0]    n_reg, n_next;

    ple_pkg::cell_cmd_t  cmd;
    logic                advance;
    logic                accept;
    logic                push;
    ple_pkg::rsp_t       push_data;

    logic signed [ple_pkg::VALUE_W-1:0] data_vec [DEPTH];
    logic [DEPTH-1:0]    match_vec;
    logic [DEPTH-1:0]    first_vec;
    logic [DEPTH:0]      prior;

    logic [ple_pkg::PTR_W-1:0] cnt_ext;
    logic [ple_pkg::PTR_W-1:0] pos_ext;
    logic                full;
    logic                any_match;
    logic                remaining;
    logic                last_hit;
    logic                search_go;
    logic [ple_pkg::POS_W-1:0] pos_hit;

    // result queue
    ple_pkg::rsp_t       q_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          q_cnt_reg;
    logic                q_full;
    logic                pop;

    // cell chain
    assign prior[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [ple_pkg::VALUE_W-1:0] left_d;
        logic signed [ple_pkg::VALUE_W-1:0] right_d;

        if (i == 0)
        begin : g_head
            assign left_d = req.value;
        end
        else
        begin : g_left
            assign left_d = data_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_d = data_vec[i];
        end
        else
        begin : g_right
            assign right_d = data_vec[i+1];
        end

        ple_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .advance    (advance),
            .prior_in   (prior[i]),
            .data       (data_vec[i]),
            .match      (match_vec[i]),
            .first      (first_vec[i]),
            .prior_out  (prior[i+1])
        );
    end

    assign cnt_ext   = ple_pkg::PTR_W'(count_reg);
    assign pos_ext   = ple_pkg::PTR_W'(req.position);
    assign full      = (count_reg == FULL_COUNT);
    assign any_match = prior[DEPTH];
    assign remaining = |(match_vec & ~first_vec);
    assign last_hit  = !remaining || (n_reg == LAST_RES);
    assign search_go = accept && (req.op == ple_pkg::OP_SEARCH) && (count_reg != '0);

    always_comb
    begin
        pos_hit = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_vec[i])
            begin
                pos_hit = pos_hit | ple_pkg::POS_W'(i + 1);
            end
        end
    end

    assign q_full    = (q_cnt_reg == 2'd2);
    assign req.ready = (state_reg == ple_pkg::S_IDLE) && !q_full;
    assign accept    = req.valid && req.ready;
    assign pop       = rsp.valid && rsp.ready;

    // request decode and search sequencing
    always_comb
    begin
        state_next             = state_reg;
        count_next             = count_reg;
        n_next                 = n_reg;
        advance                = 1'b0;
        push                   = 1'b0;
        cmd.act                = ple_pkg::ACT_NONE;
        cmd.idx                = '0;
        cmd.count              = cnt_ext;
        cmd.value              = req.value;
        push_data.status       = ple_pkg::ST_OK;
        push_data.position_res = '0;
        push_data.last         = 1'b1;

        unique case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    case (req.op)
                        ple_pkg::OP_INS_FRONT,
                        ple_pkg::OP_INS_END,
                        ple_pkg::OP_INS_AT:
                        begin
                            if (full)
                            begin
                                push_data.status = ple_pkg::ST_FULL;
                            end
                            else if (req.op == ple_pkg::OP_INS_FRONT)
                            begin
                                cmd.act    = ple_pkg::ACT_INSERT;
                                cmd.idx    = '0;
                                count_next = count_reg + 1'b1;
                            end
                            else if (req.op == ple_pkg::OP_INS_END)
                            begin
                                cmd.act    = ple_pkg::ACT_INSERT;
                                cmd.idx    = cnt_ext;
                                count_next = count_reg + 1'b1;
                            end
                            else if (pos_ext != '0 && pos_ext <= cnt_ext
                                     || pos_ext == ple_pkg::PTR_W'(1))
                            begin
                                cmd.act    = ple_pkg::ACT_INSERT;
                                cmd.idx    = pos_ext - 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                push_data.status = ple_pkg::ST_RANGE;
                            end
                        end
                        ple_pkg::OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                push_data.status = ple_pkg::ST_EMPTY;
                            end
                            else if (pos_ext != '0 && pos_ext <= cnt_ext)
                            begin
                                cmd.act    = ple_pkg::ACT_DELETE;
                                cmd.idx    = pos_ext - 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                push_data.status = ple_pkg::ST_RANGE;
                            end
                        end
                        ple_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                push_data.status = ple_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // latch match flags now, report them in S_SEARCH
                                push       = 1'b0;
                                cmd.act    = ple_pkg::ACT_SEARCH;
                                n_next     = '0;
                                state_next = ple_pkg::S_SEARCH;
                            end
                        end
                        default:
                        begin
                            push_data.status = ple_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ple_pkg::S_SEARCH:
            begin
                if (!q_full)
                begin
                    push = 1'b1;
                    if (!any_match)
                    begin
                        push_data.status = ple_pkg::ST_NOT_FOUND;
                        state_next       = ple_pkg::S_IDLE;
                    end
                    else
                    begin
                        push_data.status       = ple_pkg::ST_FOUND;
                        push_data.position_res = pos_hit;
                        push_data.last         = last_hit;
                        advance                = 1'b1;
                        n_next                 = n_reg + 1'b1;
                        if (last_hit)
                        begin
                            state_next = ple_pkg::S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase

        push_data.count = ple_pkg::POS_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ple_pkg::S_IDLE;
            count_reg <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
        end
    end

    // two-entry result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                q_cnt_reg <= q_cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                q_cnt_reg <= q_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign rsp.valid        = (q_cnt_reg != 2'd0);
    assign rsp.status       = q_reg[rd_ptr_reg].status;
    assign rsp.position_res = q_reg[rd_ptr_reg].position_res;
    assign rsp.count        = q_reg[rd_ptr_reg].count;
    assign rsp.last         = q_reg[rd_ptr_reg].last;

    // checks
    `PLE_ASSERT(a_count_bound, count_reg <= FULL_COUNT, "entry count above depth")
    `PLE_ASSERT(a_single_hit, !advance || $onehot(first_vec), "match scan picked not one cell")
    `PLE_ASSERT(a_push_room, !push || !q_full || pop, "result queue overflow")
    `PLE_ASSERT_NEXT(a_search_start, search_go, state_reg == ple_pkg::S_SEARCH, "no scan")

endmodule

`default_nettype wire
